// ----- rtl/core/rspc_pkg.sv -----
// ----------------------------------------------------------------------------
// rspc_pkg
// Shared constants and sector tables for the six-sector PWM compare block.
// ----------------------------------------------------------------------------
package rspc_pkg;

   localparam int SAMPLE_BITS_DEF = 16;
   localparam int REG_BITS        = 16;
   localparam int DUTY_BITS       = 17;
   localparam int CSR_IDX_BITS    = 3;
   localparam int SECTOR_BITS     = 3;
   localparam int OUT_BITS        = 112;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_GAIN_AC    = 3'd0,
      CSR_GAIN_BA    = 3'd1,
      CSR_PWM_PERIOD = 3'd2,
      CSR_MIN_PULSE  = 3'd3,
      CSR_DEAD_TIME  = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      SEL_P1 = 2'd0,
      SEL_D  = 2'd1,
      SEL_DD = 2'd2
   } cmp_sel_type;

   typedef enum logic [1:0] {
      PH_A = 2'd0,
      PH_B = 2'd1,
      PH_C = 2'd2
   } phase_type;

   function automatic logic [SECTOR_BITS-1:0] sector_of(input logic [2:0] code);
      logic [SECTOR_BITS-1:0] s;
      case (code)
         3'd1:    s = 3'd5;
         3'd2:    s = 3'd3;
         3'd3:    s = 3'd4;
         3'd4:    s = 3'd1;
         3'd5:    s = 3'd6;
         3'd6:    s = 3'd2;
         default: s = 3'd0;
      endcase
      return s;
   endfunction

   function automatic phase_type num_of(input logic [SECTOR_BITS-1:0] sec);
      phase_type p;
      case (sec)
         3'd1, 3'd2: p = PH_B;
         3'd3, 3'd4: p = PH_C;
         default:    p = PH_A;
      endcase
      return p;
   endfunction

   function automatic phase_type den_of(input logic [SECTOR_BITS-1:0] sec);
      phase_type p;
      case (sec)
         3'd2, 3'd5: p = PH_C;
         3'd3, 3'd6: p = PH_B;
         default:    p = PH_A;
      endcase
      return p;
   endfunction

   // Order of j: a4, b4, a5, b5, a6, b6.
   function automatic cmp_sel_type cmp_of(input logic [SECTOR_BITS-1:0] sec,
                                          input logic [2:0] j);
      cmp_sel_type c;
      c = SEL_P1;
      case (sec)
         3'd1: if (j == 3'd3) c = SEL_D; else if (j == 3'd5) c = SEL_DD;
         3'd2: if (j == 3'd0) c = SEL_DD; else if (j == 3'd2) c = SEL_D;
         3'd3: if (j == 3'd1) c = SEL_DD; else if (j == 3'd5) c = SEL_D;
         3'd4: if (j == 3'd2) c = SEL_DD; else if (j == 3'd4) c = SEL_D;
         3'd5: if (j == 3'd1) c = SEL_D; else if (j == 3'd3) c = SEL_DD;
         3'd6: if (j == 3'd0) c = SEL_D; else if (j == 3'd4) c = SEL_DD;
         default: c = SEL_P1;
      endcase
      return c;
   endfunction

   function automatic logic [5:0] force_of(input logic [SECTOR_BITS-1:0] sec);
      logic [5:0] f;
      case (sec)
         3'd1, 3'd6: f = 6'h09;
         3'd2, 3'd3: f = 6'h24;
         3'd4, 3'd5: f = 6'h12;
         default:    f = 6'h00;
      endcase
      return f;
   endfunction

endpackage

// ----- rtl/core/rectifier_sector_pwm_compare.sv -----
// ----------------------------------------------------------------------------
// rectifier_sector_pwm_compare
// Sector detection and compare generation for a three-phase PWM rectifier.
// ----------------------------------------------------------------------------
// Channel  Direction  Payload (low bit up)
// req_     in         volt_ac_sample, volt_ba_sample
// rsp_     out        sector, cmp_a4, cmp_b4, cmp_a5, cmp_b5, cmp_a6, cmp_b6, mask
// csr_     in         register writes, index 0..4
//
// One transaction enters per cycle while rsp_ is not stalled.
// A 17-stage restoring divider forms the duty, one quotient bit per stage.
// Reset clears the valid bits and loads the register defaults.
// A stalled rsp_ holds every stage and deasserts req_tready.
module rectifier_sector_pwm_compare #(
   parameter int SAMPLE_BITS = rspc_pkg::SAMPLE_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // volt_ac_sample, volt_ba_sample
   input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // sector, cmp_a4, cmp_b4, cmp_a5, cmp_b5, cmp_a6, cmp_b6, force_high_mask
   output logic [rspc_pkg::OUT_BITS-1:0] rsp_tdata,
   input  logic csr_wr_en,
   input  logic [rspc_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [rspc_pkg::REG_BITS-1:0] csr_wdata
);
   localparam int PW  = SAMPLE_BITS + 17;
   localparam int PHW = PW + 2;
   localparam int MW  = PW;
   localparam int DW  = MW + rspc_pkg::REG_BITS;
   localparam int QB  = rspc_pkg::DUTY_BITS;
   localparam int SW  = MW + QB;
   localparam int NST = QB + 6;

   logic [15:0] gain_ac_ff, gain_ba_ff, period_ff, min_pulse_ff, dead_time_ff;
   logic [NST-1:0] vld_ff, vld_in;
   logic en;

   logic signed [PW-1:0] x_ff, y_ff;
   logic signed [PHW-1:0] pa_ff, pb_ff, pc_ff;
   logic [2:0] sec3_ff, sec4_ff;
   logic [MW-1:0] n3_ff, d3_ff, d4_ff;
   logic [DW-1:0] prod_ff;
   logic z4_ff;
   logic [DW-1:0] rem_ff [QB+1];
   logic [MW-1:0] dv_ff [QB+1];
   logic [2:0] sv_ff [QB+1];
   logic [QB-1:0] q_ff [QB+1];
   logic sat_ff [QB+1];
   logic z_ff [QB+1];
   logic [rspc_pkg::OUT_BITS-1:0] out_ff;

   logic signed [PW-1:0] x_in, y_in;
   logic signed [PHW-1:0] xe, ye;
   logic [2:0] code;
   logic [2:0] sec_in;
   logic signed [PHW-1:0] num_ph, den_ph;
   logic [QB-1:0] duty, dmax;
   logic [15:0] d16, dd16, p1;
   logic [QB:0] dd_sum;
   logic [QB-1:0] p1_sum;
   logic [15:0] cmp [6];
   logic [rspc_pkg::OUT_BITS-1:0] out_in;

   assign en         = !vld_ff[NST-1] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[NST-1];
   assign rsp_tdata  = out_ff;
   assign vld_in     = {vld_ff[NST-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ac_ff   <= 16'd256;
         gain_ba_ff   <= 16'd256;
         period_ff    <= 16'd1000;
         min_pulse_ff <= 16'd0;
         dead_time_ff <= 16'd0;
      end else if (csr_wr_en) begin
         case (csr_index)
            rspc_pkg::CSR_GAIN_AC:    gain_ac_ff   <= csr_wdata;
            rspc_pkg::CSR_GAIN_BA:    gain_ba_ff   <= csr_wdata;
            rspc_pkg::CSR_PWM_PERIOD: period_ff    <= csr_wdata;
            rspc_pkg::CSR_MIN_PULSE:  min_pulse_ff <= csr_wdata;
            rspc_pkg::CSR_DEAD_TIME:  dead_time_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   assign x_in = PW'($signed(req_tdata[SAMPLE_BITS-1:0]) * $signed({1'b0, gain_ac_ff}));
   assign y_in = PW'($signed(req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]) *
                     $signed({1'b0, gain_ba_ff}));
   assign xe   = PHW'(x_ff);
   assign ye   = PHW'(y_ff);
   assign code = {!pa_ff[PHW-1], !pb_ff[PHW-1], !pc_ff[PHW-1]};
   assign sec_in = rspc_pkg::sector_of(code);

   always_comb begin
      case (rspc_pkg::num_of(sec_in))
         rspc_pkg::PH_B: num_ph = pb_ff;
         rspc_pkg::PH_C: num_ph = pc_ff;
         default:        num_ph = pa_ff;
      endcase
      case (rspc_pkg::den_of(sec_in))
         rspc_pkg::PH_B: den_ph = pb_ff;
         rspc_pkg::PH_C: den_ph = pc_ff;
         default:        den_ph = pa_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         pa_ff   <= xe - ye;
         pb_ff   <= xe + (ye <<< 1);
         pc_ff   <= -((xe <<< 1) + ye);
         sec3_ff <= sec_in;
         n3_ff   <= MW'(num_ph[PHW-1] ? -num_ph : num_ph);
         d3_ff   <= MW'(den_ph[PHW-1] ? -den_ph : den_ph);
         prod_ff <= DW'(n3_ff * period_ff);
         d4_ff   <= d3_ff;
         sec4_ff <= sec3_ff;
         z4_ff   <= (d3_ff == '0);
         rem_ff[0] <= prod_ff;
         dv_ff[0]  <= d4_ff;
         sv_ff[0]  <= sec4_ff;
         q_ff[0]   <= '0;
         z_ff[0]   <= z4_ff;
         sat_ff[0] <= SW'(prod_ff) >= {d4_ff, QB'(0)};
      end
   end

   for (genvar k = 0; k < QB; k++) begin : g_div
      localparam int SH = QB - 1 - k;
      logic [SW-1:0] dsh;
      logic take;
      assign dsh  = SW'(dv_ff[k]) << SH;
      assign take = SW'(rem_ff[k]) >= dsh;
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1] <= take ? DW'(SW'(rem_ff[k]) - dsh) : rem_ff[k];
            q_ff[k+1]   <= q_ff[k] | (QB'(take) << SH);
            dv_ff[k+1]  <= dv_ff[k];
            sv_ff[k+1]  <= sv_ff[k];
            z_ff[k+1]   <= z_ff[k];
            sat_ff[k+1] <= sat_ff[k];
         end
      end
   end

   always_comb begin
      duty = z_ff[QB] ? '0 : (sat_ff[QB] ? {1'b1, 16'd0} : q_ff[QB]);
      dmax = (duty <= QB'(min_pulse_ff)) ? QB'(min_pulse_ff) : duty;
      d16  = dmax[QB-1] ? 16'hFFFF : dmax[15:0];
      dd_sum = (QB+1)'(dmax) + (QB+1)'(dead_time_ff);
      dd16 = (dd_sum[QB:16] != '0) ? 16'hFFFF : dd_sum[15:0];
      p1_sum = QB'(period_ff) + QB'(1);
      p1   = p1_sum[16] ? 16'hFFFF : p1_sum[15:0];
      for (int j = 0; j < 6; j++) begin
         case (rspc_pkg::cmp_of(sv_ff[QB], 3'(j)))
            rspc_pkg::SEL_D:  cmp[j] = d16;
            rspc_pkg::SEL_DD: cmp[j] = dd16;
            default:          cmp[j] = p1;
         endcase
      end
      out_in = {7'd0, rspc_pkg::force_of(sv_ff[QB]), cmp[5], cmp[4], cmp[3],
                cmp[2], cmp[1], cmp[0], sv_ff[QB]};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= out_in;
      end
   end

endmodule

// ----- rtl/core/rspc_checker.sv -----
// ----------------------------------------------------------------------------
// rspc_checker
// Port-level checks for the six-sector PWM compare block.
// ----------------------------------------------------------------------------
module rspc_checker (
   input logic clock,
   input logic reset,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [rspc_pkg::OUT_BITS-1:0] rsp_tdata
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("Stalled transaction changed.");

   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("Input ready does not follow the output stall.");

   a_idle_sector: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] == 3'd0 |-> rsp_tdata[104:99] == 6'd0)
      else $error("Sector zero with forced levels.");

   a_sector_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:0] != 3'd7)
      else $error("Sector code out of range.");

endmodule

bind rectifier_sector_pwm_compare rspc_checker u_rspc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
